// ===== hw/rtl/tvgs_pkg.sv =====
// Shared definitions for the trilinear vector grid sampler.
// Holds parameter defaults, opcodes, register indexes and the sequencer state type.
// No dependencies.
`default_nettype none

package tvgs_pkg;

    // Parameter defaults
    localparam int DEF_GRID_X   = 32;
    localparam int DEF_GRID_Y   = 32;
    localparam int DEF_GRID_Z   = 32;
    localparam int DEF_SAMPLE_W = 32;
    localparam int DEF_FRAC_W   = 16;

    // Configuration port geometry
    localparam int CFG_ADDR_W = 5;

    // Item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register indexes (byte address / 4)
    localparam logic [2:0] CFG_X_ORIGIN = 3'd0;
    localparam logic [2:0] CFG_Y_ORIGIN = 3'd1;
    localparam logic [2:0] CFG_Z_ORIGIN = 3'd2;
    localparam logic [2:0] CFG_X_SCALE  = 3'd3;
    localparam logic [2:0] CFG_Y_SCALE  = 3'd4;
    localparam logic [2:0] CFG_Z_SCALE  = 3'd5;

    // Query sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_MUL,
        ST_MAP_CHK,
        ST_FETCH,
        ST_DRAIN,
        ST_BL_LOAD,
        ST_BL_WRITE,
        ST_EDGE_RD,
        ST_EDGE_CAP,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tvgs_blend.sv =====
// Shared blend unit: result = a + floor((b - a) * w / 2^FRAC_W).
// Two-step: multiply into a register, then add. Depends on tvgs_pkg.
`default_nettype none

module tvgs_blend import tvgs_pkg::*; #(
    parameter int SAMPLE_W = DEF_SAMPLE_W,
    parameter int FRAC_W   = DEF_FRAC_W
) (
    input  wire logic                       aclk,
    input  wire logic                       load,
    input  wire logic signed [SAMPLE_W-1:0] a_in,
    input  wire logic signed [SAMPLE_W-1:0] b_in,
    input  wire logic        [FRAC_W-1:0]   w_in,
    output logic signed      [SAMPLE_W-1:0] result
);

    localparam int PW = SAMPLE_W + FRAC_W + 2;

    logic signed [SAMPLE_W:0] diff;
    logic signed [PW-1:0]     prod;
    logic signed [PW-1:0]     prod_reg;
    logic signed [SAMPLE_W-1:0] a_reg;

    // Form the weighted difference
    assign diff = (SAMPLE_W + 1)'(b_in) - (SAMPLE_W + 1)'(a_in);
    assign prod = PW'(diff) * $signed({1'b0, w_in});

    // Hold the product and base for the add step
    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod;
            a_reg    <= a_in;
        end
    end

    // Floor shift and add back the base
    assign result = a_reg + SAMPLE_W'(prod_reg >>> FRAC_W);

endmodule

`default_nettype wire

// ===== hw/rtl/trilinear_vector_grid_sampler.sv =====
// Trilinear vector grid sampler, top level.
// Uses tvgs_pkg and instantiates tvgs_blend.
//
// A write beat (op=0) stores one grid vector. A query beat (op=1) maps the three axes in turn
// through one shared 32x32 multiplier. A position outside the grid stops at the check of the
// first axis that falls outside and returns a zero vector. A position on an upper edge reads
// one corner and takes its result from that corner. Otherwise each of the three components
// reads the eight corners through the single grid memory port and runs seven blends through
// the one blend unit. The block takes no new beat while a query is in progress; a finished
// result waits in the output register. The grid memory has no reset; a query may only touch
// entries already written.
`default_nettype none

module trilinear_vector_grid_sampler import tvgs_pkg::*; #(
    parameter int GRID_X   = DEF_GRID_X,
    parameter int GRID_Y   = DEF_GRID_Y,
    parameter int GRID_Z   = DEF_GRID_Z,
    parameter int SAMPLE_W = DEF_SAMPLE_W,
    parameter int FRAC_W   = DEF_FRAC_W
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    // input channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_op,
    input  wire logic [4:0]            s_entry_x,
    input  wire logic [4:0]            s_entry_y,
    input  wire logic [4:0]            s_entry_z,
    input  wire logic signed [31:0]    s_entry_bx,
    input  wire logic signed [31:0]    s_entry_by,
    input  wire logic signed [31:0]    s_entry_bz,
    input  wire logic signed [31:0]    s_pos_x,
    input  wire logic signed [31:0]    s_pos_y,
    input  wire logic signed [31:0]    s_pos_z,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [31:0]         m_field_x,
    output logic signed [31:0]         m_field_y,
    output logic signed [31:0]         m_field_z,
    output logic                       m_inside_res
);

    localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(GRID_X);
    localparam int YW    = $clog2(GRID_Y);
    localparam int ZW    = $clog2(GRID_Z);
    localparam int VW    = 3 * SAMPLE_W;

    // configuration registers
    logic signed [31:0] x_origin_reg, y_origin_reg, z_origin_reg;
    logic        [31:0] x_scale_reg, y_scale_reg, z_scale_reg;
    logic        [2:0]  cfg_idx;
    logic               cfg_we;

    // sequencer
    state_t      state_reg, state_next;
    logic [1:0]  ax_reg;
    logic [2:0]  cnt_reg;
    logic [2:0]  step_reg;
    logic [1:0]  comp_reg;
    logic        rv_reg;
    logic [2:0]  rv_idx_reg;
    logic        m_valid_reg;
    logic        out_load;

    // query datapath
    logic signed [31:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [63:0]        prod_reg;
    logic               neg_reg, scz_reg;
    logic               inside_reg, edge_reg;
    logic [XW-1:0]      xi_reg;
    logic [YW-1:0]      yi_reg;
    logic [ZW-1:0]      zi_reg;
    logic [FRAC_W-1:0]  xw_reg, yw_reg, zw_reg;
    logic signed [SAMPLE_W-1:0] q_reg [8];
    logic signed [SAMPLE_W-1:0] res_reg [3];

    logic signed [31:0] sel_pos, sel_org;
    logic        [31:0] sel_scale, nm1;
    logic signed [32:0] diff;
    logic        [31:0] mul_a;
    logic               axis_out, axis_edge;
    logic [FRAC_W-1:0]  w_sel;
    logic signed [SAMPLE_W-1:0] blend_res;

    // grid memory
    logic [VW-1:0] mem [CELLS];
    logic [VW-1:0] rd_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [2:0]    corner;
    logic [XW-1:0] cx;
    logic [YW-1:0] cy;
    logic [ZW-1:0] cz;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    // write one register per access beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_origin_reg <= '0;
            y_origin_reg <= '0;
            z_origin_reg <= '0;
            x_scale_reg  <= 32'd65536;
            y_scale_reg  <= 32'd65536;
            z_scale_reg  <= 32'd65536;
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_X_ORIGIN: x_origin_reg <= pwdata;
                CFG_Y_ORIGIN: y_origin_reg <= pwdata;
                CFG_Z_ORIGIN: z_origin_reg <= pwdata;
                CFG_X_SCALE:  x_scale_reg  <= pwdata;
                CFG_Y_SCALE:  y_scale_reg  <= pwdata;
                CFG_Z_SCALE:  z_scale_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (cfg_idx)
            CFG_X_ORIGIN: prdata = x_origin_reg;
            CFG_Y_ORIGIN: prdata = y_origin_reg;
            CFG_Z_ORIGIN: prdata = z_origin_reg;
            CFG_X_SCALE:  prdata = x_scale_reg;
            CFG_Y_SCALE:  prdata = y_scale_reg;
            CFG_Z_SCALE:  prdata = z_scale_reg;
            default:      prdata = '0;
        endcase
    end

    // ---------------- axis mapping ----------------
    always_comb begin
        case (ax_reg)
            2'd0: begin
                sel_pos = pos_x_reg; sel_org = x_origin_reg; sel_scale = x_scale_reg;
                nm1 = 32'(GRID_X - 1);
            end
            2'd1: begin
                sel_pos = pos_y_reg; sel_org = y_origin_reg; sel_scale = y_scale_reg;
                nm1 = 32'(GRID_Y - 1);
            end
            default: begin
                sel_pos = pos_z_reg; sel_org = z_origin_reg; sel_scale = z_scale_reg;
                nm1 = 32'(GRID_Z - 1);
            end
        endcase
    end

    assign diff  = 33'(sel_pos) - 33'(sel_org);
    assign mul_a = diff[32] ? 32'd0 : diff[31:0];

    assign axis_edge = (prod_reg[63:32] == nm1);
    assign axis_out  = (neg_reg && !scz_reg) || (prod_reg[63:32] > nm1) ||
                       (axis_edge && (prod_reg[31:0] != 32'd0));

    // ---------------- sequencer ----------------
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && (s_op == OP_QUERY)) state_next = ST_MAP_MUL;
            end
            ST_MAP_MUL: state_next = ST_MAP_CHK;
            ST_MAP_CHK: begin
                if (axis_out) state_next = ST_DONE;
                else if (ax_reg == 2'd2) state_next = (edge_reg || axis_edge) ? ST_EDGE_RD
                                                                               : ST_FETCH;
                else state_next = ST_MAP_MUL;
            end
            ST_FETCH: begin
                if (cnt_reg == 3'd7) state_next = ST_DRAIN;
            end
            ST_DRAIN:   state_next = ST_BL_LOAD;
            ST_BL_LOAD: state_next = ST_BL_WRITE;
            ST_BL_WRITE: begin
                if (step_reg == 3'd6) state_next = (comp_reg == 2'd2) ? ST_DONE : ST_FETCH;
                else state_next = ST_BL_LOAD;
            end
            ST_EDGE_RD:  state_next = ST_EDGE_CAP;
            ST_EDGE_CAP: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // counters and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ax_reg      <= '0;
            cnt_reg     <= '0;
            step_reg    <= '0;
            comp_reg    <= '0;
            rv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rv_reg <= (state_reg == ST_FETCH) || (state_reg == ST_EDGE_RD);
            if (state_reg == ST_IDLE) ax_reg <= '0;
            else if (state_reg == ST_MAP_CHK) ax_reg <= ax_reg + 2'd1;
            cnt_reg <= (state_reg == ST_FETCH) ? cnt_reg + 3'd1 : 3'd0;
            if (state_reg == ST_IDLE) begin
                step_reg <= '0;
                comp_reg <= '0;
            end else if (state_reg == ST_BL_WRITE) begin
                step_reg <= (step_reg == 3'd6) ? 3'd0 : step_reg + 3'd1;
                if (step_reg == 3'd6) comp_reg <= comp_reg + 2'd1;
            end
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // ---------------- blend unit ----------------
    always_comb begin
        if (step_reg inside {[3'd0:3'd3]}) w_sel = zw_reg;
        else if (step_reg inside {[3'd4:3'd5]}) w_sel = yw_reg;
        else w_sel = xw_reg;
    end

    tvgs_blend #(
        .SAMPLE_W (SAMPLE_W),
        .FRAC_W   (FRAC_W)
    ) u_blend (
        .aclk   (aclk),
        .load   (state_reg == ST_BL_LOAD),
        .a_in   (q_reg[0]),
        .b_in   (q_reg[1]),
        .w_in   (w_sel),
        .result (blend_res)
    );

    // ---------------- query datapath ----------------
    always_ff @(posedge aclk) begin
        rv_idx_reg <= cnt_reg;
        if (state_reg == ST_IDLE && s_valid) begin
            pos_x_reg  <= s_pos_x;
            pos_y_reg  <= s_pos_y;
            pos_z_reg  <= s_pos_z;
            inside_reg <= 1'b1;
            edge_reg   <= 1'b0;
        end
        if (state_reg == ST_MAP_MUL) begin
            prod_reg <= {32'd0, mul_a} * {32'd0, sel_scale};
            neg_reg  <= diff[32];
            scz_reg  <= (sel_scale == 32'd0);
        end
        if (state_reg == ST_MAP_CHK) begin
            if (axis_out) inside_reg <= 1'b0;
            edge_reg <= edge_reg || axis_edge;
            case (ax_reg)
                2'd0: begin
                    xi_reg <= prod_reg[32 +: XW];
                    xw_reg <= prod_reg[32-FRAC_W +: FRAC_W];
                end
                2'd1: begin
                    yi_reg <= prod_reg[32 +: YW];
                    yw_reg <= prod_reg[32-FRAC_W +: FRAC_W];
                end
                default: begin
                    zi_reg <= prod_reg[32 +: ZW];
                    zw_reg <= prod_reg[32-FRAC_W +: FRAC_W];
                end
            endcase
        end
        // capture the current component of each corner read
        if (rv_reg && (state_reg != ST_EDGE_CAP)) begin
            q_reg[rv_idx_reg] <= rd_reg[comp_reg*SAMPLE_W +: SAMPLE_W];
        end
        if (state_reg == ST_EDGE_CAP) begin
            for (int k = 0; k < 3; k++) res_reg[k] <= rd_reg[k*SAMPLE_W +: SAMPLE_W];
        end
        // drop the consumed pair and append the blend result
        if (state_reg == ST_BL_WRITE) begin
            for (int i = 0; i < 6; i++)
                q_reg[i] <= (3'(i) == 3'd6 - step_reg) ? blend_res : q_reg[i+2];
            if (step_reg == 3'd0) q_reg[6] <= blend_res;
            if (step_reg == 3'd6) res_reg[comp_reg] <= blend_res;
        end
        if (out_load) begin
            m_field_x    <= inside_reg ? 32'(res_reg[0]) : 32'sd0;
            m_field_y    <= inside_reg ? 32'(res_reg[1]) : 32'sd0;
            m_field_z    <= inside_reg ? 32'(res_reg[2]) : 32'sd0;
            m_inside_res <= inside_reg;
        end
    end

    assign m_valid = m_valid_reg;

    // ---------------- grid memory ----------------
    assign mem_we = s_valid && s_ready && (s_op == OP_WRITE) &&
                    (32'(s_entry_x) < GRID_X) && (32'(s_entry_y) < GRID_Y) &&
                    (32'(s_entry_z) < GRID_Z);
    assign wr_addr = (AW'(s_entry_x) * AW'(GRID_Y) + AW'(s_entry_y)) * AW'(GRID_Z)
                     + AW'(s_entry_z);

    assign mem_re = (state_reg == ST_FETCH) || (state_reg == ST_EDGE_RD);
    assign corner = (state_reg == ST_FETCH) ? cnt_reg : 3'd0;
    assign cx = xi_reg + XW'(corner[2]);
    assign cy = yi_reg + YW'(corner[1]);
    assign cz = zi_reg + ZW'(corner[0]);
    assign rd_addr = (AW'(cx) * AW'(GRID_Y) + AW'(cy)) * AW'(GRID_Z) + AW'(cz);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= {SAMPLE_W'(s_entry_bz), SAMPLE_W'(s_entry_by),
                             SAMPLE_W'(s_entry_bx)};
        end
        if (mem_re) rd_reg <= mem[rd_addr];
    end

`ifndef SYNTHESIS
    // an outside result carries a zero vector
    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_inside_res |-> (m_field_x == 0) && (m_field_y == 0) &&
                                     (m_field_z == 0))
        else $error("outside result with nonzero vector");

    // input is taken only while no query is in progress
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == ST_IDLE) && !rv_reg)
        else $error("ready during a query");

    // the last blend of the last component leads to the result stage
    a_last_blend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BL_WRITE) && (step_reg == 3'd6) && (comp_reg == 2'd2)
        |=> (state_reg == ST_DONE) && inside_reg)
        else $error("missed result after last blend");

    // memory data arrives only in states that capture it
    a_read_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        rv_reg |-> (state_reg == ST_FETCH) || (state_reg == ST_DRAIN) ||
                   (state_reg == ST_EDGE_CAP))
        else $error("grid read data not captured");
`endif

endmodule

`default_nettype wire
